[src/rfs_pkg.sv]
// Package for the radio frame splitter: result record, result kinds,
// header sync bytes and configuration register indexes. No dependencies.
package rfs_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int RES_IDX_W   = 3;

    localparam logic [7:0]  SYNC_A        = 8'h9F;
    localparam logic [7:0]  SYNC_B        = 8'hE4;
    localparam logic [7:0]  OWN_ID_RESET  = 8'h03;
    localparam logic [15:0] MASK_BIT0     = 16'h0001;

    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_SHORT    = 3'd1;
    localparam logic [2:0] KIND_STALE    = 3'd2;
    localparam logic [2:0] KIND_OVERFLOW = 3'd3;
    localparam logic [2:0] KIND_BAD      = 3'd4;
    localparam logic [2:0] KIND_SUMMARY  = 3'd5;

    localparam logic REG_OWN_ID = 1'b0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  sender;
        logic [7:0]  payload;
        logic [6:0]  offset;
        logic [15:0] mask;
        logic [7:0]  total;
        logic        junk;
    } result_t;

    typedef struct packed {
        logic                 load;
        logic [RES_IDX_W-1:0] count;
    } buf_load_t;

    function automatic result_t make_result(input logic [2:0] kind,
                                            input logic [7:0] sender,
                                            input logic [7:0] payload,
                                            input logic [6:0] offset,
                                            input logic [15:0] mask,
                                            input logic [7:0] total,
                                            input logic junk);
        result_t r;
        r.kind    = kind;
        r.sender  = sender;
        r.payload = payload;
        r.offset  = offset;
        r.mask    = mask;
        r.total   = total;
        r.junk    = junk;
        return r;
    endfunction

endpackage

[src/radio_frame_splitter.sv]
// Radio frame splitter top level: input register, frame and chunk state,
// per-sender fill counts and APB register. Depends on rfs_pkg, rfs_result_buf.
//
// Takes one received byte per beat (tlast marks the end of a serial read) and
// accepts a new beat every cycle while m_tready is high and each beat causes at
// most one result. A beat with more results (up to four at chunk end) stalls
// the input side until its last result is taken, as the result buffer drains
// one beat per cycle while m_tready is high. A beat is held in the input
// register and its results in the result buffer. The per-sender fill counts
// are flip-flops cleared at once at chunk end: no clearing pass after reset.
module radio_frame_splitter import rfs_pkg::*; #(
    parameter int SENDER_SLOTS = 16,
    parameter int BUFFER_BYTES = 128,
    parameter int HEADER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // chunk_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // sender_id[7:0], payload_byte[15:8], buffer_offset[22:16],
    // connected_mask[38:23], frame_total[46:39], junk_first[47]
    output logic [47:0] m_tdata,
    output logic [2:0]  m_tuser,   // result_kind
    output logic        m_tlast,   // run_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [7:0]        HDR_LEN  = 8'(HEADER_BYTES);
    localparam logic [7:0]        SLOT_LIM = 8'(SENDER_SLOTS);
    localparam logic [FILL_W-1:0] FILL_LIM = FILL_W'(BUFFER_BYTES);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_end_reg;
    logic              process;

    logic [7:0]        own_id_reg;
    logic [15:0]       window_reg, window_next;
    logic [1:0]        wcnt_reg, wcnt_next;
    logic              open_reg, open_next;
    logic [7:0]        pos_reg, pos_next;
    logic [7:0]        sender_reg, sender_next;
    logic [FILL_W-1:0] fill_reg [SENDER_SLOTS];
    logic [FILL_W-1:0] fill_next;
    logic              fill_wr;
    logic [15:0]       seen_reg, seen_next;
    logic [7:0]        fcount_reg, fcount_next;
    logic              junk_reg, junk_next;
    logic              clear_chunk;

    logic [15:0]       own_bit;
    logic [FILL_W-1:0] cur_fill;
    logic              hdr;
    logic [7:0]        byte_sel [3];
    logic [2:0]        byte_en;
    logic [7:0]        bt;
    logic [7:0]        off8;
    result_t           res [MAX_RESULTS];
    logic [RES_IDX_W-1:0] nres;
    buf_load_t         ld;
    logic              can_load;
    result_t           out_res;
    logic              cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_OWN_ID) ? {24'd0, own_id_reg} : 32'd0;

    assign process  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || process;

    assign own_bit  = (own_id_reg < 8'd16) ? (MASK_BIT0 << own_id_reg[3:0]) : 16'd0;
    assign cur_fill = (sender_reg < SLOT_LIM) ? fill_reg[sender_reg[SLOT_W-1:0]] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg <= OWN_ID_RESET;
        end else if (cfg_wr && (paddr[2] == REG_OWN_ID)) begin
            own_id_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    always_comb begin
        window_next = window_reg;
        wcnt_next   = wcnt_reg;
        open_next   = open_reg;
        pos_next    = pos_reg;
        sender_next = sender_reg;
        fill_next   = cur_fill;
        fill_wr     = 1'b0;
        seen_next   = seen_reg;
        fcount_next = fcount_reg;
        junk_next   = junk_reg;
        nres        = '0;
        bt          = 8'd0;
        off8        = 8'd0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k] = '0;
        end

        hdr = (wcnt_reg >= 2'd2) && (window_reg[15:8] == SYNC_A)
              && (window_reg[7:0] == SYNC_B) && (in_byte_reg == own_id_reg);

        byte_sel[0] = window_reg[15:8];
        byte_sel[1] = window_reg[7:0];
        byte_sel[2] = in_byte_reg;
        if (hdr) begin
            byte_en = {in_end_reg, 2'b00};
        end else if (wcnt_reg >= 2'd2) begin
            byte_en = {in_end_reg, in_end_reg, 1'b1};
        end else if (wcnt_reg == 2'd1) begin
            byte_en = {in_end_reg, in_end_reg, 1'b0};
        end else begin
            byte_en = {in_end_reg, 2'b00};
        end

        if (hdr) begin
            if (open_reg) begin
                if (pos_reg < HDR_LEN) begin
                    res[nres] = make_result(KIND_SHORT, sender_reg, 8'd0, 7'd0,
                                            16'd0, 8'd0, 1'b0);
                    nres = RES_IDX_W'(nres + 1'b1);
                end else if (sender_reg >= SLOT_LIM) begin
                    res[nres] = make_result(KIND_BAD, sender_reg, 8'd0, 7'd0,
                                            16'd0, 8'd0, 1'b0);
                    nres = RES_IDX_W'(nres + 1'b1);
                end else if (pos_reg == HDR_LEN && cur_fill != '0) begin
                    res[nres] = make_result(KIND_STALE, sender_reg, 8'd0, 7'd0,
                                            16'd0, 8'd0, 1'b0);
                    nres = RES_IDX_W'(nres + 1'b1);
                end
                if (sender_reg != 8'd0 && sender_reg < SLOT_LIM) begin
                    seen_next[sender_reg[3:0]] = 1'b1;
                end
            end
            open_next   = 1'b1;
            pos_next    = 8'd2;
            sender_next = 8'd0;
            if (fcount_reg != 8'hFF) begin
                fcount_next = fcount_reg + 8'd1;
            end
            window_next = {8'd0, in_byte_reg};
            wcnt_next   = 2'd1;
        end else if (wcnt_reg >= 2'd2) begin
            window_next = {window_reg[7:0], in_byte_reg};
            wcnt_next   = 2'd2;
        end else begin
            window_next = {window_reg[7:0], in_byte_reg};
            wcnt_next   = 2'(wcnt_reg + 1'b1);
        end

        for (int i = 0; i < 3; i++) begin
            if (byte_en[i]) begin
                bt = byte_sel[i];
                if (!open_next) begin
                    junk_next = 1'b1;
                end else begin
                    if (pos_next == 8'd3) begin
                        sender_next = bt;
                        fill_next   = (bt < SLOT_LIM) ? fill_reg[bt[SLOT_W-1:0]] : '0;
                    end
                    if (pos_next >= HDR_LEN && sender_next < SLOT_LIM) begin
                        if (fill_next >= FILL_LIM) begin
                            res[nres] = make_result(KIND_OVERFLOW, sender_next, 8'd0,
                                                    7'd0, 16'd0, 8'd0, 1'b0);
                            nres = RES_IDX_W'(nres + 1'b1);
                        end else begin
                            off8 = 8'(fill_next);
                            res[nres] = make_result(KIND_PAYLOAD, sender_next, bt,
                                                    off8[6:0], 16'd0, 8'd0, 1'b0);
                            nres = RES_IDX_W'(nres + 1'b1);
                            fill_next = FILL_W'(fill_next + 1'b1);
                            fill_wr = 1'b1;
                        end
                    end
                    if (pos_next != 8'hFF) begin
                        pos_next = pos_next + 8'd1;
                    end
                end
            end
        end

        if (in_end_reg) begin
            if (open_next) begin
                if (pos_next < HDR_LEN) begin
                    res[nres] = make_result(KIND_SHORT, sender_next, 8'd0, 7'd0,
                                            16'd0, 8'd0, 1'b0);
                    nres = RES_IDX_W'(nres + 1'b1);
                end else if (sender_next >= SLOT_LIM) begin
                    res[nres] = make_result(KIND_BAD, sender_next, 8'd0, 7'd0,
                                            16'd0, 8'd0, 1'b0);
                    nres = RES_IDX_W'(nres + 1'b1);
                end else if (pos_next == HDR_LEN && fill_next != '0) begin
                    res[nres] = make_result(KIND_STALE, sender_next, 8'd0, 7'd0,
                                            16'd0, 8'd0, 1'b0);
                    nres = RES_IDX_W'(nres + 1'b1);
                end
                if (sender_next != 8'd0 && sender_next < SLOT_LIM) begin
                    seen_next[sender_next[3:0]] = 1'b1;
                end
            end
            res[nres] = make_result(KIND_SUMMARY, 8'd0, 8'd0, 7'd0,
                                    seen_next | own_bit, fcount_next, junk_next);
            nres = RES_IDX_W'(nres + 1'b1);
        end
    end

    assign clear_chunk = in_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            wcnt_reg   <= '0;
            open_reg   <= 1'b0;
            pos_reg    <= '0;
            sender_reg <= '0;
            seen_reg   <= MASK_BIT0 << OWN_ID_RESET[3:0];
            fcount_reg <= '0;
            junk_reg   <= 1'b0;
        end else if (process) begin
            if (clear_chunk) begin
                window_reg <= '0;
                wcnt_reg   <= '0;
                open_reg   <= 1'b0;
                pos_reg    <= '0;
                sender_reg <= '0;
                seen_reg   <= own_bit;
                fcount_reg <= '0;
                junk_reg   <= 1'b0;
            end else begin
                window_reg <= window_next;
                wcnt_reg   <= wcnt_next;
                open_reg   <= open_next;
                pos_reg    <= pos_next;
                sender_reg <= sender_next;
                seen_reg   <= seen_next;
                fcount_reg <= fcount_next;
                junk_reg   <= junk_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SENDER_SLOTS; j++) begin
                fill_reg[j] <= '0;
            end
        end else if (process) begin
            if (clear_chunk) begin
                for (int j = 0; j < SENDER_SLOTS; j++) begin
                    fill_reg[j] <= '0;
                end
            end else if (fill_wr) begin
                fill_reg[sender_next[SLOT_W-1:0]] <= fill_next;
            end
        end
    end

    assign ld.load  = process;
    assign ld.count = nres;

    rfs_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ld        (ld),
        .ld_data   (res),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .out_last  (m_tlast)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {out_res.junk, out_res.total, out_res.mask,
                      out_res.offset, out_res.payload, out_res.sender};

endmodule

[src/rfs_result_buf.sv]
// Result buffer of the radio frame splitter: holds one input beat's results
// and gives them out one beat per cycle while out_ready is high. Uses rfs_pkg.
module rfs_result_buf import rfs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  buf_load_t ld,
    input  result_t   ld_data [MAX_RESULTS],
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_data,
    output logic      out_last
);

    result_t              entry_reg [MAX_RESULTS];
    logic [RES_IDX_W-1:0] num_reg;
    logic [RES_IDX_W-1:0] rd_reg;
    logic [RES_IDX_W-1:0] rd_inc;
    logic [RES_IDX_W-1:0] rd_idx;
    logic                 pop;

    assign rd_inc    = RES_IDX_W'(rd_reg + 1'b1);
    assign out_valid = (rd_reg != num_reg);
    assign pop       = out_valid && out_ready;
    assign can_load  = !out_valid || (pop && (rd_inc == num_reg));
    assign rd_idx    = out_valid ? rd_reg : '0;
    assign out_data  = entry_reg[rd_idx];
    assign out_last  = (rd_inc == num_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= '0;
            rd_reg  <= '0;
        end else if (ld.load) begin
            num_reg <= ld.count;
            rd_reg  <= '0;
        end else if (pop) begin
            rd_reg <= rd_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.load) begin
            entry_reg <= ld_data;
        end
    end

endmodule

[src/rfs_checker.sv]
// Port-level checker for the radio frame splitter, attached by bind below.
// Depends on rfs_pkg and radio_frame_splitter.
module rfs_checker import rfs_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SUMMARY) |-> m_tlast)
        else $error("chunk summary is not the last beat of its run");

    a_summary_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_SUMMARY) |-> (m_tdata[47:23] == 25'd0))
        else $error("summary fields set on a non-summary beat");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_PAYLOAD) || (m_tuser == KIND_SHORT)
                  || (m_tuser == KIND_STALE) || (m_tuser == KIND_OVERFLOW)
                  || (m_tuser == KIND_BAD) || (m_tuser == KIND_SUMMARY))
        else $error("undefined result kind");

    a_after_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == KIND_SUMMARY) |=>
            !m_tvalid || (m_tuser != KIND_STALE))
        else $error("stale frame reported right after a chunk summary");

endmodule

bind radio_frame_splitter rfs_checker u_rfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[tb/sv/rfs_result_checker.sv]
// Result checker for radio_frame_splitter: follows register writes and input
// beats, predicts the result beats and compares them with the output channel.
// Depends on rfs_pkg.
module rfs_result_checker import rfs_pkg::*; #(
    parameter int SENDER_SLOTS = 16,
    parameter int BUFFER_BYTES = 128,
    parameter int HEADER_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_results
);

    localparam logic [2:0] OWN_ID_ADDR = 3'(4 * REG_OWN_ID);

    typedef struct packed {
        result_t res;
        logic    last;
    } result_beat_t;

    logic [7:0]  own_id;
    logic [15:0] look_behind;
    logic [1:0]  held_bytes;
    logic        frame_live;
    logic [7:0]  frame_pos;
    logic [7:0]  frame_src;
    logic [7:0]  fill [SENDER_SLOTS];
    logic [15:0] seen_senders;
    logic [7:0]  frames_found;
    logic        stray_bytes;

    result_t      step_results[$];
    result_beat_t due_results[$];

    int fails = 0;
    int pending = 0;

    assign mismatch_count  = fails;
    assign pending_results = pending;

    function automatic logic [15:0] own_bit();
        return (own_id < 16) ? (MASK_BIT0 << own_id[3:0]) : 16'h0000;
    endfunction

    function automatic void add_result(input logic [2:0] kind, input logic [7:0] sender,
                                       input logic [7:0] payload, input logic [6:0] offset,
                                       input logic [15:0] mask, input logic [7:0] total,
                                       input logic junk);
        result_t r;
        r.kind    = kind;
        r.sender  = sender;
        r.payload = payload;
        r.offset  = offset;
        r.mask    = mask;
        r.total   = total;
        r.junk    = junk;
        if (step_results.size() < MAX_RESULTS)
            step_results.push_back(r);
    endfunction

    function automatic void place_byte(input logic [7:0] value);
        int s;
        if (!frame_live) begin
            stray_bytes = 1'b1;
            return;
        end
        if (frame_pos == 8'd3)
            frame_src = value;
        s = frame_src;
        if (frame_pos >= HEADER_BYTES && s < SENDER_SLOTS) begin
            if (fill[s] >= BUFFER_BYTES) begin
                add_result(KIND_OVERFLOW, frame_src, 8'h00, 7'h00, 16'h0000, 8'h00, 1'b0);
            end else begin
                add_result(KIND_PAYLOAD, frame_src, value, fill[s][6:0], 16'h0000, 8'h00,
                           1'b0);
                fill[s] = fill[s] + 8'd1;
            end
        end
        if (frame_pos != 8'hFF)
            frame_pos = frame_pos + 8'd1;
    endfunction

    function automatic void close_frame();
        int s;
        if (!frame_live)
            return;
        s = frame_src;
        if (frame_pos < HEADER_BYTES)
            add_result(KIND_SHORT, frame_src, 8'h00, 7'h00, 16'h0000, 8'h00, 1'b0);
        else if (s >= SENDER_SLOTS)
            add_result(KIND_BAD, frame_src, 8'h00, 7'h00, 16'h0000, 8'h00, 1'b0);
        else if (frame_pos == HEADER_BYTES && fill[s] > 0)
            add_result(KIND_STALE, frame_src, 8'h00, 7'h00, 16'h0000, 8'h00, 1'b0);
        if (s != 0 && s < SENDER_SLOTS && s < 16)
            seen_senders = seen_senders | (MASK_BIT0 << frame_src[3:0]);
        frame_live = 1'b0;
    endfunction

    function automatic void clear_chunk();
        look_behind  = 16'h0000;
        held_bytes   = 2'd0;
        frame_live   = 1'b0;
        frame_pos    = 8'h00;
        frame_src    = 8'h00;
        foreach (fill[i])
            fill[i] = 8'h00;
        seen_senders = own_bit();
        frames_found = 8'h00;
        stray_bytes  = 1'b0;
    endfunction

    function automatic void split_byte(input logic [7:0] value, input logic read_end);
        logic [7:0] older;
        logic [7:0] newer;
        older = look_behind[15:8];
        newer = look_behind[7:0];
        step_results.delete();
        if (held_bytes >= 2 && older == SYNC_A && newer == SYNC_B && value == own_id) begin
            close_frame();
            frame_live = 1'b1;
            frame_pos  = 8'd2;
            frame_src  = 8'h00;
            if (frames_found != 8'hFF)
                frames_found = frames_found + 8'd1;
            look_behind = {8'h00, value};
            held_bytes  = 2'd1;
        end else if (held_bytes >= 2) begin
            place_byte(older);
            look_behind = {newer, value};
            held_bytes  = 2'd2;
        end else begin
            look_behind = {look_behind[7:0], value};
            held_bytes  = held_bytes + 2'd1;
        end
        if (read_end) begin
            if (held_bytes >= 2)
                place_byte(look_behind[15:8]);
            if (held_bytes >= 1)
                place_byte(look_behind[7:0]);
            close_frame();
            add_result(KIND_SUMMARY, 8'h00, 8'h00, 7'h00, seen_senders | own_bit(),
                       frames_found, stray_bytes);
            clear_chunk();
        end
        foreach (step_results[i])
            due_results.push_back('{res: step_results[i],
                                    last: (i == step_results.size() - 1)});
    endfunction

    function automatic void note_fail(input string msg);
        if (fails < 10)
            $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
            note_fail($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    always @(posedge aclk) begin
        result_beat_t want;
        if (!aresetn) begin
            own_id = OWN_ID_RESET;
            clear_chunk();
            due_results.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == OWN_ID_ADDR)
                own_id = pwdata[7:0];
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    note_fail($sformatf("unexpected result beat kind %0d tdata %h",
                                        m_tuser, m_tdata));
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", 16'(want.res.kind), 16'(m_tuser));
                    check_field("sender_id", 16'(want.res.sender), 16'(m_tdata[7:0]));
                    check_field("payload_byte", 16'(want.res.payload), 16'(m_tdata[15:8]));
                    check_field("buffer_offset", 16'(want.res.offset), 16'(m_tdata[22:16]));
                    check_field("connected_mask", want.res.mask, m_tdata[38:23]);
                    check_field("frame_total", 16'(want.res.total), 16'(m_tdata[46:39]));
                    check_field("junk_first", 16'(want.res.junk), 16'(m_tdata[47]));
                    check_field("run_last", 16'(want.last), 16'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                split_byte(s_tdata, s_tlast);
            pending <= due_results.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for radio_frame_splitter: drives serial reads and register
// writes with random stalls, and gives the verdict from rfs_result_checker.
// Depends on rfs_pkg, radio_frame_splitter and rfs_result_checker.
module tb_top;
    import rfs_pkg::*;

    localparam logic [2:0] OWN_ID_ADDR  = 3'(4 * REG_OWN_ID);
    localparam int         HEADER_LEN   = 8;
    localparam int         BUFFER_LEN   = 128;
    localparam int         RANDOM_BEATS = 70;
    localparam int         STALL_LIMIT  = 1000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;

    logic [7:0] read_bytes[$];
    bit         carry_id     = 1'b0;
    int         tx_gap_pct   = 0;
    int         rx_stall_pct = 0;
    int         rx_hold      = 0;
    int         quiet_cycles = 0;
    int         random_beats = 0;

    always #6 aclk = ~aclk;

    radio_frame_splitter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rfs_result_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatches),
        .pending_results (pending)
    );

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 13);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] value, input logic read_end);
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= read_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_chunk();
        foreach (read_bytes[i])
            send_beat(read_bytes[i], i == read_bytes.size() - 1);
        read_bytes.delete();
    endtask

    // hold the input side until every pending result is out and the pipe is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void add_frame(input logic [7:0] id, input logic [7:0] sender,
                                      input int len);
        read_bytes.push_back(SYNC_A);
        read_bytes.push_back(SYNC_B);
        read_bytes.push_back(id);
        if (len > 3)
            read_bytes.push_back(sender);
        for (int k = 4; k < len; k++)
            read_bytes.push_back(8'($urandom()));
    endfunction

    function automatic void build_random_read(input logic [7:0] id);
        int         frames;
        int         pick;
        int         len;
        logic [7:0] sender;
        if (carry_id) begin
            read_bytes.push_back(id);
            carry_id = 1'b0;
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 6)) read_bytes.push_back(8'($urandom()));
        frames = $urandom_range(0, 2);
        repeat (frames) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                sender = 8'($urandom_range(0, 3));
            else if (pick < 8)
                sender = 8'($urandom_range(0, 15));
            else
                sender = 8'($urandom_range(16, 255));
            pick = $urandom_range(0, 5);
            if (pick == 0)
                len = $urandom_range(3, 7);
            else if (pick == 1)
                len = HEADER_LEN;
            else
                len = $urandom_range(HEADER_LEN + 1, 20);
            if ($urandom_range(0, 11) == 0) begin
                read_bytes.push_back(SYNC_A);
                read_bytes.push_back(SYNC_B);
                read_bytes.push_back(~id);
            end
            add_frame(id, sender, len);
        end
        // split a header across two reads
        if ($urandom_range(0, 9) == 0) begin
            read_bytes.push_back(SYNC_A);
            read_bytes.push_back(SYNC_B);
            carry_id = 1'b1;
        end
        if (read_bytes.size() == 0)
            read_bytes.push_back(8'($urandom()));
    endfunction

    initial begin
        logic [7:0] phase_ids [8];
        int         target;
        phase_ids    = '{8'h00, 8'hFF, 8'h0F, 8'h10, SYNC_A, SYNC_B, OWN_ID_RESET, 8'h00};
        phase_ids[7] = 8'($urandom());

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        read_bytes.push_back(8'h00);
        add_frame(OWN_ID_RESET, 8'h05, HEADER_LEN);
        read_bytes.push_back(8'hFF);
        read_bytes.push_back(8'h00);
        add_frame(OWN_ID_RESET, 8'h05, HEADER_LEN);
        add_frame(OWN_ID_RESET, 8'h80, HEADER_LEN + 1);
        add_frame(OWN_ID_RESET, 8'h00, 3);
        send_chunk();
        read_bytes.push_back(8'hFF);
        send_chunk();

        // overlapping headers when the own id equals the first sync byte
        wait_drained();
        reg_write(OWN_ID_ADDR, {24'($urandom()), SYNC_A});
        read_bytes.push_back(SYNC_A);
        read_bytes.push_back(SYNC_B);
        add_frame(SYNC_A, 8'h0A, HEADER_LEN + 1);
        send_chunk();

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            reg_write(OWN_ID_ADDR, {24'($urandom()), phase_ids[p]});
            tx_gap_pct   = (p == 7 || p % 3 == 2) ? 0 : 10;
            rx_stall_pct = (p == 7 || p % 2 == 1) ? 0 : 8;
            if (p == 3) begin
                add_frame(phase_ids[p], 8'h02, HEADER_LEN);
                repeat (BUFFER_LEN + 4) read_bytes.push_back(8'($urandom()));
                send_chunk();
            end
            target = (p < 7) ? (p + 1) * (RANDOM_BEATS - 30) / 7 : RANDOM_BEATS;
            while (random_beats < target) begin
                build_random_read(phase_ids[p]);
                random_beats += read_bytes.size();
                send_chunk();
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
src/rfs_pkg.sv
src/rfs_result_buf.sv
src/radio_frame_splitter.sv
src/rfs_checker.sv
tb/sv/rfs_result_checker.sv
tb/sv/tb_top.sv
